// ===== hw/rtl/pclt_pkg.sv =====
// Shared types and constants for the polyphonic chord latch with transpose.
package pclt_pkg;

	localparam int CHANNELS = 16;
	localparam int LVL_W    = 16;
	localparam int ADDR_W   = $clog2(CHANNELS);
	localparam int CNT_W    = 5;
	localparam int CH_W     = 4;

	localparam logic signed [LVL_W-1:0] LVL_MAX = {1'b0, {(LVL_W-1){1'b1}}};
	localparam logic signed [LVL_W-1:0] LVL_MIN = {1'b1, {(LVL_W-1){1'b0}}};

	typedef struct packed {
		logic                    latch_switch;
		logic                    latch_jack_connected;
		logic signed [LVL_W-1:0] latch_jack_level;
		logic [CNT_W-1:0]        gate_count;
		logic [CNT_W-1:0]        pitch_count;
		logic [CH_W-1:0]         channel;
		logic signed [LVL_W-1:0] gate_level;
		logic signed [LVL_W-1:0] pitch_level;
		logic signed [LVL_W-1:0] transpose_pitch;
		logic signed [LVL_W-1:0] transpose_gate_level;
	} item_t;

	typedef struct packed {
		logic [CH_W-1:0]         out_channel;
		logic signed [LVL_W-1:0] gate_out;
		logic                    gate_write;
		logic signed [LVL_W-1:0] pitch_out;
		logic                    pitch_write;
		logic [CNT_W-1:0]        gate_count_out;
		logic [CNT_W-1:0]        pitch_count_out;
		logic                    latched_out;
	} result_t;

	// Per-item control handed from the frame controller to the result stage.
	typedef struct packed {
		logic [CH_W-1:0]         channel;
		logic                    latched;
		logic                    gate_on;
		logic                    gate_write;
		logic                    pitch_write;
		logic                    held;
		logic signed [LVL_W-1:0] gate_pass;
		logic signed [LVL_W-1:0] pitch_pass;
		logic signed [LVL_W-1:0] lowest;
		logic signed [LVL_W-1:0] transpose;
		logic [CNT_W-1:0]        gate_count;
		logic [CNT_W-1:0]        pitch_count;
	} ctrl_t;

endpackage

// ===== hw/rtl/pclt_ram.sv =====
// Simple dual-port RAM, one write and one registered read port.
module pclt_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hw/rtl/pclt_frame_ctrl.sv =====
// Frame controller: latch decision, counts, transpose phase, held notes and lowest pitch.
module pclt_frame_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         accept,
	input  pclt_pkg::item_t              item,
	output pclt_pkg::ctrl_t              ctrl,
	output logic                         in_range,
	output logic                         gate_we,
	output logic                         pitch_we,
	output logic [pclt_pkg::ADDR_W-1:0]  addr
);

	typedef enum logic [1:0] {
		PH_ARMED,
		PH_GATE_LOW,
		PH_TRANSPOSE
	} phase_t;

	phase_t                                  phase_q, phase_n;
	logic                                    latched_q, latched_n;
	logic                                    gate_on_q, gate_on_n;
	logic [pclt_pkg::CNT_W-1:0]              gcnt_q, gcnt_n;
	logic [pclt_pkg::CNT_W-1:0]              pcnt_q, pcnt_n;
	logic signed [pclt_pkg::LVL_W-1:0]       run_low_q, run_low_n;
	logic signed [pclt_pkg::LVL_W-1:0]       lowest_q, lowest_n;
	logic [pclt_pkg::CHANNELS-1:0]           held_q, held_n;
	logic                                    lat, on, gw, pw;

	assign addr = pclt_pkg::ADDR_W'(item.channel);

	always_comb begin
		phase_n   = phase_q;
		latched_n = latched_q;
		gate_on_n = gate_on_q;
		gcnt_n    = gcnt_q;
		pcnt_n    = pcnt_q;
		run_low_n = run_low_q;
		lowest_n  = lowest_q;
		held_n    = held_q;
		lat       = 1'b0;
		on        = 1'b0;
		gw        = 1'b0;
		pw        = 1'b0;
		gate_we   = 1'b0;
		pitch_we  = 1'b0;
		in_range  = 32'(item.channel) < 32'(pclt_pkg::CHANNELS);

		if (in_range) begin
			if (item.channel == '0) begin
				lat = item.latch_jack_connected ? (item.latch_jack_level > 0)
				                                : item.latch_switch;
				latched_n = lat;
				if (!lat) begin
					gcnt_n    = (item.gate_count > pclt_pkg::CNT_W'(pclt_pkg::CHANNELS))
					            ? pclt_pkg::CNT_W'(pclt_pkg::CHANNELS) : item.gate_count;
					pcnt_n    = (item.pitch_count > pclt_pkg::CNT_W'(pclt_pkg::CHANNELS))
					            ? pclt_pkg::CNT_W'(pclt_pkg::CHANNELS) : item.pitch_count;
					run_low_n = pclt_pkg::LVL_MAX;
					phase_n   = PH_ARMED;
				end else begin
					on        = item.transpose_gate_level > 0;
					gate_on_n = on;
					if (!on && phase_q == PH_ARMED) begin
						phase_n = PH_GATE_LOW;
					end else if (on && phase_q == PH_GATE_LOW) begin
						phase_n = PH_TRANSPOSE;
					end
				end
			end

			if (!latched_n) begin
				gw           = pclt_pkg::CNT_W'(item.channel) < gcnt_n;
				pw           = gw && (item.gate_level != 0)
				               && (pclt_pkg::CNT_W'(item.channel) < pcnt_n);
				held_n[addr] = pw;
				gate_we      = gw;
				pitch_we     = pw;
				if (pw && item.pitch_level < run_low_n) begin
					run_low_n = item.pitch_level;
				end
				if (32'(item.channel) == 32'(pclt_pkg::CHANNELS - 1)) begin
					lowest_n = run_low_n;
				end
			end else begin
				gw = pclt_pkg::CNT_W'(item.channel) < gcnt_n;
				pw = (phase_n == PH_TRANSPOSE)
				     && (pclt_pkg::CNT_W'(item.channel) < pcnt_n);
			end
		end

		ctrl.channel     = item.channel;
		ctrl.latched     = latched_n;
		ctrl.gate_on     = gate_on_n;
		ctrl.gate_write  = gw;
		ctrl.pitch_write = pw;
		ctrl.held        = held_q[addr];
		ctrl.gate_pass   = gw ? item.gate_level : '0;
		ctrl.pitch_pass  = pw ? item.pitch_level : '0;
		ctrl.lowest      = lowest_q;
		ctrl.transpose   = item.transpose_pitch;
		ctrl.gate_count  = gcnt_n;
		ctrl.pitch_count = pcnt_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_ARMED;
			latched_q <= 1'b0;
			gate_on_q <= 1'b0;
			gcnt_q    <= '0;
			pcnt_q    <= '0;
			run_low_q <= pclt_pkg::LVL_MAX;
			lowest_q  <= pclt_pkg::LVL_MAX;
			held_q    <= '0;
		end else if (accept) begin
			phase_q   <= phase_n;
			latched_q <= latched_n;
			gate_on_q <= gate_on_n;
			gcnt_q    <= gcnt_n;
			pcnt_q    <= pcnt_n;
			run_low_q <= run_low_n;
			lowest_q  <= lowest_n;
			held_q    <= held_n;
		end
	end

endmodule

// ===== hw/rtl/pclt_result.sv =====
// Result stage: combines store read data with item control, then the output register.
module pclt_result (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              item_valid,
	output logic                              item_ready,
	input  pclt_pkg::ctrl_t                   ctrl,
	input  logic signed [pclt_pkg::LVL_W-1:0] gate_rd,
	input  logic signed [pclt_pkg::LVL_W-1:0] pitch_rd,
	output logic                              result_valid,
	input  logic                              result_ready,
	output pclt_pkg::result_t                 result
);

	pclt_pkg::ctrl_t                   ctrl_s1;
	logic                              valid_s1;
	logic                              advance;
	logic signed [pclt_pkg::LVL_W:0]   off;
	logic signed [pclt_pkg::LVL_W+1:0] sum;
	logic signed [pclt_pkg::LVL_W-1:0] sat;
	pclt_pkg::result_t                 res;

	assign advance    = !result_valid || result_ready;
	assign item_ready = !valid_s1 || advance;

	always_comb begin
		// Offset from the chord's lowest note, plus transpose, clamped.
		off = ctrl_s1.held ? ({pitch_rd[pclt_pkg::LVL_W-1], pitch_rd}
		                      - {ctrl_s1.lowest[pclt_pkg::LVL_W-1], ctrl_s1.lowest}) : '0;
		sum = {off[pclt_pkg::LVL_W], off}
		      + {{2{ctrl_s1.transpose[pclt_pkg::LVL_W-1]}}, ctrl_s1.transpose};
		if (sum > (pclt_pkg::LVL_W+2)'(pclt_pkg::LVL_MAX)) begin
			sat = pclt_pkg::LVL_MAX;
		end else if (sum < (pclt_pkg::LVL_W+2)'(pclt_pkg::LVL_MIN)) begin
			sat = pclt_pkg::LVL_MIN;
		end else begin
			sat = pclt_pkg::LVL_W'(sum);
		end

		res.out_channel     = ctrl_s1.channel;
		res.gate_write      = ctrl_s1.gate_write;
		res.pitch_write     = ctrl_s1.pitch_write;
		res.gate_count_out  = ctrl_s1.gate_count;
		res.pitch_count_out = ctrl_s1.pitch_count;
		res.latched_out     = ctrl_s1.latched;
		if (!ctrl_s1.latched) begin
			res.gate_out  = ctrl_s1.gate_pass;
			res.pitch_out = ctrl_s1.pitch_pass;
		end else begin
			res.gate_out  = (ctrl_s1.gate_write && ctrl_s1.gate_on) ? gate_rd : '0;
			res.pitch_out = ctrl_s1.pitch_write ? sat : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			if (item_ready) begin
				valid_s1 <= item_valid;
			end
			if (advance) begin
				result_valid <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			ctrl_s1 <= ctrl;
		end
		if (advance && valid_s1) begin
			result <= res;
		end
	end

endmodule

// ===== hw/rtl/poly_chord_latch_transpose_core.sv =====
// Top level of the polyphonic chord latch with transpose.
// Usage: items arrive on the item channel (valid/ready), one per channel of a
// frame, channel 0 first; channel 0 decides the latch for the frame. Each item
// gives exactly one result on the result channel (valid/ready), in order.
// The gate and pitch stores are read and the item control registered at the
// transfer edge; the output register then loads them once the receiver is
// not stalling. Throughput is one item per cycle while the result side does
// not stall, with one access to each store per item; writes of unlatched
// frames and reads of every item go through the same address in the
// transfer cycle.
// Reset (arst_n low) clears the frame state, held-note flags, counts and the
// lowest pitch to the most positive level; the stores themselves are not
// cleared and are read for every item, whether its channel was written or not.
// When the receiver stalls, the output register and the read stage hold, and
// item_ready drops once both are full; no result is lost or repeated.
module poly_chord_latch_transpose_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  pclt_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_ready,
	output pclt_pkg::result_t result
);

	pclt_pkg::ctrl_t                   ctrl;
	logic                              accept;
	logic                              in_range;
	logic                              gate_we;
	logic                              pitch_we;
	logic [pclt_pkg::ADDR_W-1:0]       addr;
	logic [pclt_pkg::LVL_W-1:0]        gate_rd;
	logic [pclt_pkg::LVL_W-1:0]        pitch_rd;

	assign accept = item_valid && item_ready;

	pclt_frame_ctrl u_frame_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.item     (item),
		.ctrl     (ctrl),
		.in_range (in_range),
		.gate_we  (gate_we),
		.pitch_we (pitch_we),
		.addr     (addr)
	);

	pclt_ram #(
		.WIDTH (pclt_pkg::LVL_W),
		.DEPTH (pclt_pkg::CHANNELS)
	) u_gate_store (
		.clk   (clk),
		.we    (accept && gate_we),
		.waddr (addr),
		.wdata (item.gate_level),
		.re    (accept && in_range),
		.raddr (addr),
		.rdata (gate_rd)
	);

	pclt_ram #(
		.WIDTH (pclt_pkg::LVL_W),
		.DEPTH (pclt_pkg::CHANNELS)
	) u_pitch_store (
		.clk   (clk),
		.we    (accept && pitch_we),
		.waddr (addr),
		.wdata (item.pitch_level),
		.re    (accept && in_range),
		.raddr (addr),
		.rdata (pitch_rd)
	);

	pclt_result u_result (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.ctrl         (ctrl),
		.gate_rd      (gate_rd),
		.pitch_rd     (pitch_rd),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the polyphonic chord latch with transpose.
`timescale 1ns / 100ps

module tb_top;

	localparam int unsigned CYCLE_LIMIT = 200000;

	typedef enum logic [1:0] {PH_ARMED, PH_GATE_LOW, PH_TRANSPOSING} phase_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              item_valid = 1'b0;
	logic              item_ready;
	pclt_pkg::item_t   voice_item = '0;
	logic              result_valid;
	logic              result_ready = 1'b0;
	pclt_pkg::result_t voice_result;

	int unsigned cycle_count = 0;
	int unsigned error_count = 0;
	int unsigned items_sent = 0;
	int unsigned results_checked = 0;
	int unsigned latched_frames = 0;
	int unsigned transposed_pitches = 0;
	int unsigned clamped_pitches = 0;
	int unsigned send_idle_pct = 16;
	int unsigned recv_idle_pct = 56;

	pclt_pkg::result_t voice_results_due[$];

	// predictor state
	logic signed [pclt_pkg::LVL_W-1:0] gate_mem [pclt_pkg::CHANNELS];
	logic signed [pclt_pkg::LVL_W-1:0] pitch_mem [pclt_pkg::CHANNELS];
	bit                                held_note [pclt_pkg::CHANNELS] = '{default: 1'b0};
	logic signed [pclt_pkg::LVL_W-1:0] chord_floor = pclt_pkg::LVL_MAX;
	logic signed [pclt_pkg::LVL_W-1:0] frame_floor = pclt_pkg::LVL_MAX;
	logic [pclt_pkg::CNT_W-1:0]        gate_span = '0;
	logic [pclt_pkg::CNT_W-1:0]        pitch_span = '0;
	phase_t                            phase = PH_ARMED;
	bit                                latched_now = 1'b0;
	bit                                mono_on = 1'b0;

	poly_chord_latch_transpose_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(voice_item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(voice_result)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	always @(posedge clk) cycle_count <= cycle_count + 1;

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("timeout after %0d cycles, %0d results still due", cycle_count,
			voice_results_due.size());
		$display("status: fail");
		$finish;
	end

	function automatic pclt_pkg::result_t predict_voice(input pclt_pkg::item_t it);
		pclt_pkg::result_t r;
		int                ch;
		bit                lat;
		bit                gated;
		longint            off;
		longint            sum;
		r = '0;
		ch = it.channel;
		if (ch == 0) begin
			lat = it.latch_jack_connected ? ($signed(it.latch_jack_level) > 0)
			                              : it.latch_switch;
			latched_now = lat;
			if (!lat) begin
				gate_span = (it.gate_count > pclt_pkg::CHANNELS)
				            ? pclt_pkg::CNT_W'(pclt_pkg::CHANNELS) : it.gate_count;
				pitch_span = (it.pitch_count > pclt_pkg::CHANNELS)
				             ? pclt_pkg::CNT_W'(pclt_pkg::CHANNELS) : it.pitch_count;
				frame_floor = pclt_pkg::LVL_MAX;
				phase = PH_ARMED;
			end else begin
				latched_frames++;
				mono_on = $signed(it.transpose_gate_level) > 0;
				if (!mono_on && phase == PH_ARMED)
					phase = PH_GATE_LOW;
				else if (mono_on && phase == PH_GATE_LOW)
					phase = PH_TRANSPOSING;
			end
		end
		if (!latched_now) begin
			gated = 1'b0;
			if (ch < gate_span) begin
				gate_mem[ch] = it.gate_level;
				r.gate_out = it.gate_level;
				r.gate_write = 1'b1;
				gated = it.gate_level != 0;
			end
			held_note[ch] = 1'b0;
			if (ch < pitch_span && gated) begin
				held_note[ch] = 1'b1;
				pitch_mem[ch] = it.pitch_level;
				if ($signed(it.pitch_level) < frame_floor) frame_floor = it.pitch_level;
				r.pitch_out = it.pitch_level;
				r.pitch_write = 1'b1;
			end
			if (ch == pclt_pkg::CHANNELS - 1) chord_floor = frame_floor;
		end else begin
			if (ch < gate_span) begin
				r.gate_out = mono_on ? gate_mem[ch] : '0;
				r.gate_write = 1'b1;
			end
			if (phase == PH_TRANSPOSING && ch < pitch_span) begin
				// offset from the chord's lowest note, kept wide until the clamp
				off = held_note[ch] ? longint'(pitch_mem[ch]) - longint'(chord_floor) : 0;
				sum = off + longint'($signed(it.transpose_pitch));
				if (sum > longint'(pclt_pkg::LVL_MAX) || sum < longint'(pclt_pkg::LVL_MIN))
					clamped_pitches++;
				if (sum > longint'(pclt_pkg::LVL_MAX)) sum = longint'(pclt_pkg::LVL_MAX);
				if (sum < longint'(pclt_pkg::LVL_MIN)) sum = longint'(pclt_pkg::LVL_MIN);
				r.pitch_out = sum[pclt_pkg::LVL_W-1:0];
				r.pitch_write = 1'b1;
				transposed_pitches++;
			end
		end
		r.out_channel = it.channel;
		r.gate_count_out = gate_span;
		r.pitch_count_out = pitch_span;
		r.latched_out = latched_now;
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		error_count++;
		$display("[%0t] mismatch on result %0d: %s", $time, results_checked, msg);
	endtask

	task automatic compare_field(input string name, input logic [pclt_pkg::LVL_W-1:0] got,
			input logic [pclt_pkg::LVL_W-1:0] want, input logic [pclt_pkg::CH_W-1:0] ch);
		if (got !== want)
			report_mismatch($sformatf("ch %0d %s got %h want %h", ch, name, got, want));
	endtask

	task automatic check_result(input pclt_pkg::result_t got);
		pclt_pkg::result_t want;
		if (voice_results_due.size() == 0) begin
			report_mismatch($sformatf("unexpected result for ch %0d", got.out_channel));
		end else begin
			want = voice_results_due.pop_front();
			compare_field("out_channel", pclt_pkg::LVL_W'(got.out_channel),
				pclt_pkg::LVL_W'(want.out_channel), want.out_channel);
			compare_field("gate_out", got.gate_out, want.gate_out, want.out_channel);
			compare_field("gate_write", pclt_pkg::LVL_W'(got.gate_write),
				pclt_pkg::LVL_W'(want.gate_write), want.out_channel);
			compare_field("pitch_out", got.pitch_out, want.pitch_out, want.out_channel);
			compare_field("pitch_write", pclt_pkg::LVL_W'(got.pitch_write),
				pclt_pkg::LVL_W'(want.pitch_write), want.out_channel);
			compare_field("gate_count_out", pclt_pkg::LVL_W'(got.gate_count_out),
				pclt_pkg::LVL_W'(want.gate_count_out), want.out_channel);
			compare_field("pitch_count_out", pclt_pkg::LVL_W'(got.pitch_count_out),
				pclt_pkg::LVL_W'(want.pitch_count_out), want.out_channel);
			compare_field("latched_out", pclt_pkg::LVL_W'(got.latched_out),
				pclt_pkg::LVL_W'(want.latched_out), want.out_channel);
		end
		results_checked++;
	endtask

	// result side: check each transfer, then pick the next ready level
	initial begin
		forever begin
			@(posedge clk);
			if (arst_n) begin
				if (result_valid && result_ready) check_result(voice_result);
				result_ready <= $urandom_range(99) >= recv_idle_pct;
			end
		end
	end

	task automatic send_item(input pclt_pkg::item_t it);
		if ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		item_valid <= 1'b1;
		voice_item <= it;
		do @(posedge clk); while (!item_ready);
		voice_results_due.push_back(predict_voice(it));
		items_sent++;
	endtask

	function automatic pclt_pkg::item_t random_item();
		return pclt_pkg::item_t'({$urandom, $urandom, $urandom});
	endfunction

	// a level strictly above zero, or one at or below zero
	function automatic logic signed [pclt_pkg::LVL_W-1:0] level_for(input bit above);
		int v;
		v = above ? int'($urandom_range(32767, 1)) : -int'($urandom_range(32768, 0));
		return v[pclt_pkg::LVL_W-1:0];
	endfunction

	function automatic pclt_pkg::item_t with_latch(input pclt_pkg::item_t it, input bit want);
		it.latch_jack_connected = 1'($urandom_range(1));
		if (it.latch_jack_connected)
			it.latch_jack_level = level_for(want);
		else
			it.latch_switch = want;
		return it;
	endfunction

	function automatic logic [pclt_pkg::CNT_W-1:0] pick_count();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 70) return pclt_pkg::CNT_W'($urandom_range(pclt_pkg::CHANNELS, 1));
		if (r < 80) return pclt_pkg::CNT_W'(pclt_pkg::CHANNELS);
		if (r < 90) return '0;
		return pclt_pkg::CNT_W'($urandom_range(31, pclt_pkg::CHANNELS + 1));
	endfunction

	// one ordered frame; pitches mostly cluster as a chord around a random root
	task automatic send_frame(input bit latch, input bit mono,
			input logic [pclt_pkg::CNT_W-1:0] gcnt, input logic [pclt_pkg::CNT_W-1:0] pcnt);
		pclt_pkg::item_t                   it;
		logic signed [pclt_pkg::LVL_W-1:0] root;
		logic signed [pclt_pkg::LVL_W-1:0] shift;
		root = pclt_pkg::LVL_W'($urandom);
		shift = ($urandom_range(3) == 0) ? pclt_pkg::LVL_W'($urandom)
		        : pclt_pkg::LVL_W'(int'($urandom_range(4095)) - 2048);
		for (int ch = 0; ch < pclt_pkg::CHANNELS; ch++) begin
			it = random_item();
			it.channel = pclt_pkg::CH_W'(ch);
			if (ch == 0) begin
				it = with_latch(it, latch);
				it.gate_count = gcnt;
				it.pitch_count = pcnt;
				it.transpose_gate_level = level_for(mono);
			end
			if ($urandom_range(99) < 15) it.gate_level = '0;
			if ($urandom_range(99) < 80)
				it.pitch_level = root + pclt_pkg::LVL_W'($urandom_range(6143));
			if ($urandom_range(9) != 0) it.transpose_pitch = shift;
			send_item(it);
		end
	endtask

	// partial or out-of-order frames
	task automatic send_noise_burst();
		pclt_pkg::item_t it;
		int unsigned     n;
		n = $urandom_range(6, 1);
		for (int k = 0; k < n; k++) begin
			it = random_item();
			if (k == 0 && $urandom_range(1)) it.channel = '0;
			send_item(it);
		end
	endtask

	task automatic test_latch_from_reset();
		pclt_pkg::item_t it;
		it = random_item();
		it.channel = '0;
		it.latch_jack_connected = 1'b1;
		it.latch_jack_level = 16'sh0001;
		it.transpose_gate_level = 16'shffff;
		send_item(it);
		it = random_item();
		it.channel = 4'd5;
		send_item(it);
	endtask

	// unlatched frame that writes every channel; switch set but jack wins
	task automatic test_chord_capture();
		pclt_pkg::item_t it;
		for (int ch = 0; ch < pclt_pkg::CHANNELS; ch++) begin
			it = random_item();
			it.channel = pclt_pkg::CH_W'(ch);
			if (it.gate_level == 0) it.gate_level = 16'sh0100;
			if (ch == 0) begin
				it.latch_switch = 1'b1;
				it.latch_jack_connected = 1'b1;
				it.latch_jack_level = '0;
				it.gate_count = pclt_pkg::CNT_W'(pclt_pkg::CHANNELS);
				it.pitch_count = 5'd31;
				it.pitch_level = pclt_pkg::LVL_MIN;
			end
			if (ch == 1) begin
				it.gate_level = pclt_pkg::LVL_MAX;
				it.pitch_level = pclt_pkg::LVL_MAX;
			end
			if (ch == 2) it.gate_level = pclt_pkg::LVL_MIN;
			if (ch == 3) it.gate_level = '0;
			send_item(it);
		end
	endtask

	task automatic test_transpose_extremes();
		pclt_pkg::item_t it;
		it = random_item();
		it.channel = '0;
		it.latch_switch = 1'b1;
		it.latch_jack_connected = 1'b0;
		it.transpose_gate_level = '0;
		send_item(it);
		// gate high again: transposition starts on this frame
		it.transpose_gate_level = 16'sh0001;
		it.transpose_pitch = pclt_pkg::LVL_MAX;
		send_item(it);
		it = random_item();
		it.channel = 4'd1;
		it.transpose_pitch = '0;
		send_item(it);
		it.channel = 4'd3;
		it.transpose_pitch = pclt_pkg::LVL_MIN;
		send_item(it);
		it = random_item();
		it.channel = 4'd15;
		send_item(it);
		it = random_item();
		it.channel = '0;
		it.latch_switch = 1'b1;
		it.latch_jack_connected = 1'b1;
		it.latch_jack_level = pclt_pkg::LVL_MIN;
		send_item(it);
	endtask

	task automatic test_random_traffic(input int unsigned n_items);
		int unsigned stop_at;
		int unsigned n_latched;
		bit          mono;
		stop_at = items_sent + n_items;
		while (items_sent < stop_at) begin
			if ($urandom_range(99) < 85) begin
				send_frame(1'b0, 1'($urandom_range(1)), pick_count(), pick_count());
				n_latched = $urandom_range(5, 1);
				for (int k = 0; k < n_latched; k++) begin
					// usually low first so the next high arms the transpose
					mono = (k == 0) ? ($urandom_range(9) == 0) : ($urandom_range(3) != 0);
					send_frame(1'b1, mono, pick_count(), pick_count());
				end
			end else begin
				send_noise_burst();
			end
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_latch_from_reset();
		test_chord_capture();
		test_transpose_extremes();
		test_random_traffic(410);
		send_idle_pct = 56;
		recv_idle_pct = 16;
		test_random_traffic(410);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_traffic(410);
		item_valid <= 1'b0;
		while (voice_results_due.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		$display("run covered %0d items and %0d results, %0d latched frames",
			items_sent, results_checked, latched_frames);
		$display("%0d transposed pitches, %0d clamped; %0d mismatches",
			transposed_pitches, clamped_pitches, error_count);
		if (error_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
